>>> rtl/core/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants for the size-class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam int unsigned NUM_CLASSES_DEF = 4;
  localparam int unsigned MAX_BLOCKS_DEF  = 1024;

  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE0_RST = 32'd16384;
  localparam logic [SIZE_W-1:0] SIZE1_RST = 32'd65536;
  localparam logic [SIZE_W-1:0] SIZE2_RST = 32'd262144;
  localparam logic [SIZE_W-1:0] SIZE3_RST = 32'd1048576;
  localparam logic [CNT_W-1:0]  MAX_BLK_RST = 11'd1024;
  localparam logic [CNT_W-1:0]  QUANTUM_RST = 11'd128;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_DONE,
    ST_FREE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic pop;
    logic take;
    logic fail;
    logic do_free;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic at_end;
    logic has_stack;
    logic can_take;
  } sts_t;

endpackage

>>> rtl/core/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Four-class segregated free-list allocator with grow-on-demand.
// ----------------------------------------------------------------------------
// A request takes start while busy is low. A free is captured and then
// applied; an allocate is captured, passes over classes one by one and then
// grants, going through a pop state first when the block comes off a freed
// stack (its memory read is registered). An allocate's result appears on
// out_* for one cycle with out_valid; it cannot be stalled. A free raises no
// out_valid. After reset busy stays high while the in-use bits are swept clear.
module size_class_block_allocator
  import scba_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_kind,
  input  logic [31:0]          in_length,
  input  logic [1:0]           in_free_class,
  input  logic [9:0]           in_free_index,
  output logic                 out_valid,
  output logic                 out_status,
  output logic [1:0]           out_granted_class,
  output logic [9:0]           out_granted_index,
  output logic                 out_grew
);

  cmd_t cmd;
  sts_t sts;
  logic ctl_busy;
  logic sweep_busy_r;
  logic [$clog2(NUM_CLASSES*MAX_BLOCKS+1)-1:0] sweep_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_busy_r <= 1'b1;
      sweep_cnt_r  <= '0;
    end else if (sweep_busy_r) begin
      sweep_cnt_r <= sweep_cnt_r + $bits(sweep_cnt_r)'(1);
      if (sweep_cnt_r == $bits(sweep_cnt_r)'(NUM_CLASSES*MAX_BLOCKS - 1))
        sweep_busy_r <= 1'b0;
    end
  end

  assign busy = ctl_busy || sweep_busy_r;

  scba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start && !sweep_busy_r),
    .busy  (ctl_busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  scba_dp #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_kind           (in_kind),
    .in_length         (in_length),
    .in_free_class     (in_free_class),
    .in_free_index     (in_free_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_class (out_granted_class),
    .out_granted_index (out_granted_index),
    .out_grew          (out_grew)
  );

endmodule

>>> rtl/core/scba_ctrl.sv
// ----------------------------------------------------------------------------
// scba_ctrl
// Request sequencer: walks classes, steers pops, grants and frees.
// ----------------------------------------------------------------------------
module scba_ctrl
  import scba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.is_free) begin
          cmd.do_free = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (sts.at_end) begin
          cmd.fail  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.has_stack) begin
          cmd.pop   = 1'b1;
          state_nxt = ST_POP;
        end else if (sts.can_take) begin
          cmd.take  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_POP: begin
        cmd.take  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DONE, ST_FREE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/scba_dp.sv
// ----------------------------------------------------------------------------
// scba_dp
// Allocator datapath: config, per-class counters, freed stacks, in-use bits.
// ----------------------------------------------------------------------------
module scba_dp
  import scba_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data,
  input  logic                  in_kind,
  input  logic [31:0]           in_length,
  input  logic [1:0]            in_free_class,
  input  logic [9:0]            in_free_index,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  output logic                  out_status,
  output logic [1:0]            out_granted_class,
  output logic [9:0]            out_granted_index,
  output logic                  out_grew
);

  localparam int unsigned CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned CXW = $clog2(NUM_CLASSES + 1);
  localparam int unsigned BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned NW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned NW2 = (NW > CNT_W) ? NW : CNT_W;
  localparam int unsigned MW  = CW + BW;

  logic [SIZE_W-1:0] bsize_r [NUM_CLASSES];
  logic [CNT_W-1:0]  max_blk_r, quantum_r;

  logic [NW-1:0] depth_r [NUM_CLASSES];
  logic [NW-1:0] fnext_r [NUM_CLASSES];
  logic [NW-1:0] fend_r  [NUM_CLASSES];
  logic [NW-1:0] grown_r [NUM_CLASSES];

  logic [BW-1:0] stack_mem [NUM_CLASSES*MAX_BLOCKS];
  logic          use_mem   [NUM_CLASSES*MAX_BLOCKS];
  logic [BW-1:0] pop_q;
  logic          use_q;

  logic           kind_r;
  logic [CXW-1:0] cls_r;
  logic [BW-1:0]  fidx_r;
  logic           fvalid_r;
  logic [BW:0]    fidx_ext;
  logic [CW-1:0]  cur;
  logic           sweep_r;
  logic [MW:0]    sweep_cnt_r;
  logic           pop_pend_r;

  // first covering class
  logic [CXW-1:0] first_cls;
  always_comb begin
    first_cls = CXW'(NUM_CLASSES);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (in_length <= bsize_r[i]) first_cls = CXW'(i);
    end
  end

  assign cur = cls_r[CW-1:0];

  // growth amount
  logic [NW2-1:0] limit, room, grow_n, grown_cur;
  logic           has_fresh;
  always_comb begin
    limit = (NW2'(max_blk_r) < NW2'(MAX_BLOCKS)) ? NW2'(max_blk_r) : NW2'(MAX_BLOCKS);
    grown_cur = NW2'(grown_r[cur]);
    room   = limit - grown_cur;
    grow_n = (room < NW2'(quantum_r)) ? room : NW2'(quantum_r);
    has_fresh = fnext_r[cur] < fend_r[cur];
  end

  assign sts.is_free   = kind_r;
  assign sts.at_end    = (cls_r >= CXW'(NUM_CLASSES));
  assign sts.has_stack = (depth_r[cur] != '0);
  assign sts.can_take  = has_fresh || ((grown_cur < limit) && (grow_n != '0));

  assign fidx_ext = {1'b0, fidx_r};

  logic [MW-1:0] pop_addr, free_addr;
  assign pop_addr  = {cur, BW'(depth_r[cur] - NW'(1))};
  assign free_addr = {cur, fidx_r};

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        unique case (i)
          0: bsize_r[i] <= SIZE0_RST;
          1: bsize_r[i] <= SIZE1_RST;
          2: bsize_r[i] <= SIZE2_RST;
          3: bsize_r[i] <= SIZE3_RST;
          default: bsize_r[i] <= '1;
        endcase
      end
      max_blk_r <= MAX_BLK_RST;
      quantum_r <= QUANTUM_RST;
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (i < 4 && cfg_index == CFG_IDX_W'(i)) bsize_r[i] <= cfg_data;
      end
      if (cfg_index == REG_MAX_BLK) max_blk_r <= cfg_data[CNT_W-1:0];
      if (cfg_index == REG_QUANTUM) quantum_r <= cfg_data[CNT_W-1:0];
    end
  end

  // request capture and in-use read for frees
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      fidx_r   <= BW'(in_free_index);
      fvalid_r <= (32'(in_free_index) < 32'(MAX_BLOCKS)) &&
                  (32'(in_free_class) < 32'(NUM_CLASSES));
      cls_r    <= (in_kind == KIND_FREE) ? CXW'(in_free_class) : first_cls;
    end else if (cmd.scan_step) begin
      cls_r <= cls_r + CXW'(1);
    end
  end

  always_ff @(posedge clk) begin
    use_q <= use_mem[{CW'(in_free_class), BW'(in_free_index)}];
    pop_q <= stack_mem[pop_addr];
  end

  // clearing sweep of in-use bits after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else if (sweep_r) begin
      sweep_cnt_r <= sweep_cnt_r + (MW+1)'(1);
      if (sweep_cnt_r == (MW+1)'(NUM_CLASSES*MAX_BLOCKS - 1)) sweep_r <= 1'b0;
    end
  end

  logic free_ok;
  assign free_ok = fvalid_r && (NW2'(fidx_ext) < grown_cur) && use_q;

  logic [BW-1:0] grant_idx;
  always_comb begin
    if (pop_pend_r) grant_idx = pop_q;
    else if (has_fresh) grant_idx = BW'(fnext_r[cur]);
    else grant_idx = BW'(grown_r[cur]);
  end

  always_ff @(posedge clk) begin
    if (sweep_r) begin
      use_mem[sweep_cnt_r[MW-1:0]] <= 1'b0;
    end else if (cmd.take) begin
      use_mem[{cur, grant_idx}] <= 1'b1;
    end else if (cmd.do_free && free_ok) begin
      use_mem[free_addr] <= 1'b0;
    end
    if (cmd.do_free && free_ok) begin
      stack_mem[{cur, BW'(depth_r[cur])}] <= fidx_r;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_pend_r <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        depth_r[i] <= '0;
        fnext_r[i] <= '0;
        fend_r[i]  <= '0;
        grown_r[i] <= '0;
      end
    end else begin
      pop_pend_r <= cmd.pop;
      if (cmd.pop) depth_r[cur] <= depth_r[cur] - NW'(1);
      if (cmd.take && !pop_pend_r) begin
        if (has_fresh) begin
          fnext_r[cur] <= fnext_r[cur] + NW'(1);
        end else begin
          fnext_r[cur] <= grown_r[cur] + NW'(1);
          fend_r[cur]  <= NW'(grown_cur + grow_n);
          grown_r[cur] <= NW'(grown_cur + grow_n);
        end
      end
      if (cmd.do_free && free_ok && (depth_r[cur] < NW'(MAX_BLOCKS))) begin
        depth_r[cur] <= depth_r[cur] + NW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.take || cmd.fail;
    end
    if (cmd.take) begin
      out_status        <= 1'b0;
      out_granted_class <= 2'(cur);
      out_granted_index <= 10'(grant_idx);
      out_grew          <= !pop_pend_r && !has_fresh;
    end else if (cmd.fail) begin
      out_status        <= 1'b1;
      out_granted_class <= '0;
      out_granted_index <= '0;
      out_grew          <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cmd.take |-> !sts.at_end)
    else $error("grant from out-of-range class");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.pop |=> cmd.take)
    else $error("pop not followed by grant");
  assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.take, cmd.fail, cmd.do_free}) <= 1)
    else $error("conflicting completion commands");

endmodule
